### src/lcu_pkg.sv
// ----------------------------------------------------------------------------
// lcu_pkg
// Types, constants and helpers shared by the legacy charset transcoder.
// ----------------------------------------------------------------------------
package lcu_pkg;

    // Mode register codes; unused codes fall back to pass-through
    typedef enum logic [2:0] {
        MODE_PASS   = 3'd0,
        MODE_LATIN1 = 3'd1,
        MODE_CP1251 = 3'd2,
        MODE_U16LE  = 3'd3,
        MODE_U16BE  = 3'd4
    } mode_t;

    localparam int unsigned GRP_BYTES = 6;   // worst case: flushed surrogate plus one unit
    localparam int unsigned ENC_BYTES = 4;   // longest UTF-8 sequence
    localparam int unsigned FLUSH_BYTES = 3; // a lone surrogate always takes three bytes

    localparam logic [1:0]  BOM_BYTES     = 2'd2;
    localparam logic [15:0] HI_SURR_FIRST = 16'hD800;
    localparam logic [15:0] HI_SURR_LAST  = 16'hDBFF;
    localparam logic [15:0] LO_SURR_FIRST = 16'hDC00;
    localparam logic [15:0] LO_SURR_LAST  = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;
    localparam logic [15:0] CYR_CAP_A     = 16'h0410;

    // windows-1251 upper half, bytes 0x80-0xBF
    localparam logic [15:0] CYR_TABLE [0:63] = '{
        16'h0402, 16'h0403, 16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h20AC, 16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
        16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h0098, 16'h2122, 16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F,
        16'h00A0, 16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7,
        16'h0401, 16'h00A9, 16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407,
        16'h00B0, 16'h00B1, 16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7,
        16'h0451, 16'h2116, 16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457
    };

    // Stream state carried between input beats
    typedef struct packed {
        logic [1:0] bom_cnt;
        logic [7:0] held_byte;
        logic       held_valid;
        logic [9:0] pend_unit;
        logic       pend_valid;
    } lcu_state_t;

    typedef logic [GRP_BYTES-1:0][7:0] grp_bytes_t;

    typedef struct packed {
        logic [ENC_BYTES-1:0][7:0] bytes;
        logic [2:0]                len;
    } utf8_seq_t;

    // Encode one code point as UTF-8, first byte in element 0
    function automatic utf8_seq_t utf8_encode(input logic [20:0] cp);
        utf8_seq_t s;
        s = '0;
        if (cp[20:7] == '0)
        begin
            s.bytes[0] = cp[7:0];
            s.len      = 3'd1;
        end
        else if (cp[20:11] == '0)
        begin
            s.bytes[0] = {3'b110, cp[10:6]};
            s.bytes[1] = {2'b10, cp[5:0]};
            s.len      = 3'd2;
        end
        else if (cp[20:16] == '0)
        begin
            s.bytes[0] = {4'b1110, cp[15:12]};
            s.bytes[1] = {2'b10, cp[11:6]};
            s.bytes[2] = {2'b10, cp[5:0]};
            s.len      = 3'd3;
        end
        else
        begin
            s.bytes[0] = {5'b11110, cp[20:18]};
            s.bytes[1] = {2'b10, cp[17:12]};
            s.bytes[2] = {2'b10, cp[11:6]};
            s.bytes[3] = {2'b10, cp[5:0]};
            s.len      = 3'd4;
        end
        return s;
    endfunction

endpackage

### src/lcu_if.sv
// ----------------------------------------------------------------------------
// lcu channel interfaces
// Valid/ready channels for document bytes, UTF-8 bytes and the mode register.
// ----------------------------------------------------------------------------
interface lcu_doc_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface lcu_utf8_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_end;

    modport source (output valid, output out_byte, output out_end, input ready);
    modport sink   (input valid, input out_byte, input out_end, output ready);
endinterface

interface lcu_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;

    modport source (output valid, output mode, input ready);
    modport sink   (input valid, input mode, output ready);
endinterface

### src/lcu_decode.sv
// ----------------------------------------------------------------------------
// lcu_decode
// Decode one document byte into the next stream state and a UTF-8 byte group.
// ----------------------------------------------------------------------------
module lcu_decode
    import lcu_pkg::*;
(
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    input  logic [2:0]  mode,
    input  lcu_state_t  state,
    output lcu_state_t  state_next,
    output grp_bytes_t  grp,
    output logic [2:0]  grp_cnt
);

    logic        flush;      // emit the pending high surrogate first
    logic        cp_valid;
    logic        raw;        // copy the byte unchanged
    logic [20:0] cp;
    logic [15:0] unit;
    utf8_seq_t   flush_seq;
    utf8_seq_t   cp_seq;

    always_comb
    begin
        state_next = state;
        flush      = 1'b0;
        cp_valid   = 1'b0;
        raw        = 1'b0;
        cp         = {13'd0, in_byte};
        unit       = (mode == MODE_U16LE) ? {in_byte, state.held_byte}
                                          : {state.held_byte, in_byte};
        case (mode)
            MODE_U16LE, MODE_U16BE:
            begin
                if (state.bom_cnt < BOM_BYTES)
                begin
                    state_next.bom_cnt = state.bom_cnt + 2'd1;
                end
                else if (!state.held_valid)
                begin
                    state_next.held_byte  = in_byte;
                    state_next.held_valid = 1'b1;
                end
                else
                begin
                    state_next.held_byte  = '0;
                    state_next.held_valid = 1'b0;
                    if (state.pend_valid && (unit inside {[LO_SURR_FIRST:LO_SURR_LAST]}))
                    begin
                        cp       = SUPP_BASE + {1'b0, state.pend_unit, unit[9:0]};
                        cp_valid = 1'b1;
                        state_next.pend_unit  = '0;
                        state_next.pend_valid = 1'b0;
                    end
                    else
                    begin
                        flush = state.pend_valid;
                        state_next.pend_unit  = '0;
                        state_next.pend_valid = 1'b0;
                        if ((unit inside {[HI_SURR_FIRST:HI_SURR_LAST]}) && !in_last)
                        begin
                            state_next.pend_unit  = unit[9:0];
                            state_next.pend_valid = 1'b1;
                        end
                        else
                        begin
                            cp       = {5'd0, unit};
                            cp_valid = 1'b1;
                        end
                    end
                end
                // end of document flushes a surrogate still waiting
                if (in_last && state_next.pend_valid)
                begin
                    flush = 1'b1;
                end
            end
            MODE_LATIN1:
            begin
                cp_valid = 1'b1;
            end
            MODE_CP1251:
            begin
                cp_valid = 1'b1;
                if (in_byte[7:6] == 2'b10)
                begin
                    cp = {5'd0, CYR_TABLE[in_byte[5:0]]};
                end
                else if (in_byte[7:6] == 2'b11)
                begin
                    cp = {5'd0, CYR_CAP_A + {10'd0, in_byte[5:0]}};
                end
            end
            default:
            begin
                cp_valid = 1'b1;
                raw      = 1'b1;
            end
        endcase
        if (in_last)
        begin
            state_next = '0;
        end
    end

    assign flush_seq = utf8_encode({5'd0, HI_SURR_FIRST[15:10], state.pend_unit});

    always_comb
    begin
        cp_seq = utf8_encode(cp);
        if (raw)
        begin
            cp_seq          = '0;
            cp_seq.bytes[0] = in_byte;
            cp_seq.len      = 3'd1;
        end
        if (!cp_valid)
        begin
            cp_seq.len = 3'd0;
        end
    end

    // Pack the flushed surrogate and the code point back to back
    always_comb
    begin
        grp = '0;
        for (int i = 0; i < GRP_BYTES; i++)
        begin
            if (flush)
            begin
                if (i < FLUSH_BYTES)
                    grp[i] = flush_seq.bytes[i];
                else if (i - FLUSH_BYTES < ENC_BYTES)
                    grp[i] = cp_seq.bytes[i - FLUSH_BYTES];
            end
            else if (i < ENC_BYTES)
            begin
                grp[i] = cp_seq.bytes[i];
            end
        end
        grp_cnt = (flush ? 3'(FLUSH_BYTES) : 3'd0) + cp_seq.len;
    end

endmodule

### src/legacy_charset_to_utf8_transcoder_core.sv
// ----------------------------------------------------------------------------
// legacy_charset_to_utf8_transcoder_core
// Byte-wide transcoder from pass-through, Latin-1, windows-1251 and UTF-16
// documents to a UTF-8 byte stream.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Payload                  | Beat
//  --------+-----+--------------------------+-------------------------------
//  doc     | in  | in_byte[7:0], in_last    | one document byte
//  utf8    | out | out_byte[7:0], out_end   | one UTF-8 byte
//  cfg     | in  | mode[2:0]                | one mode register write
//
//  Each doc beat yields 0 to 6 UTF-8 bytes, one per cycle unless utf8 stalls,
//  paced by the one-byte-wide output register. An accepted beat is decoded
//  in the same cycle into a byte group register, which feeds the output
//  register; a doc beat is taken while the last byte of the group moves out.
//  Stalls on utf8 hold the output register and then the group. Reset clears
//  mode, stream state and all valid flags.
//
module legacy_charset_to_utf8_transcoder_core
    import lcu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    lcu_doc_if.sink           doc,
    lcu_utf8_if.source        utf8,
    lcu_cfg_if.sink           cfg
);

    logic [2:0]  mode_reg;
    lcu_state_t  state_reg;
    lcu_state_t  state_next;
    grp_bytes_t  grp_reg;
    grp_bytes_t  grp_next;
    grp_bytes_t  dec_grp;
    logic [2:0]  dec_cnt;
    logic [2:0]  rem_reg;       // bytes left in the group
    logic [2:0]  rem_next;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_end_reg;
    logic        doc_accept;
    logic        move;          // group head advances into the output register

    // Mode register: always ready; write it only while the stream is idle (the block does not enforce this)
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_PASS;
        else if (cfg.valid)
            mode_reg <= cfg.mode;
    end

    lcu_decode u_decode (
        .in_byte    (doc.in_byte),
        .in_last    (doc.in_last),
        .mode       (mode_reg),
        .state      (state_reg),
        .state_next (state_next),
        .grp        (dec_grp),
        .grp_cnt    (dec_cnt)
    );

    // Advance the group whenever the output register is free or draining
    assign move       = (rem_reg != 3'd0) && (!out_valid_reg || utf8.ready);
    assign doc.ready  = (rem_reg == 3'd0) || ((rem_reg == 3'd1) && move);
    assign doc_accept = doc.valid && doc.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (doc_accept)
            state_reg <= state_next;
    end

    always_comb
    begin
        grp_next = grp_reg;
        rem_next = rem_reg;
        if (doc_accept)
        begin
            // load a fresh group; a beat with no output leaves it empty
            grp_next = dec_grp;
            rem_next = dec_cnt;
        end
        else if (move)
        begin
            // drop the head byte, shift the rest down
            grp_next = grp_reg >> 8;
            rem_next = rem_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rem_reg <= '0;
        else
            rem_reg <= rem_next;
    end

    always_ff @(posedge clk)
    begin
        grp_reg <= grp_next;
    end

    // Output register: hold on stall, refill from the group head
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (move)
            out_valid_reg <= 1'b1;
        else if (utf8.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_byte_reg <= grp_reg[0];
            out_end_reg  <= (rem_reg == 3'd1);
        end
    end

    assign utf8.valid    = out_valid_reg;
    assign utf8.out_byte = out_byte_reg;
    assign utf8.out_end  = out_end_reg;

endmodule

### src/lcu_checker.sv
// ----------------------------------------------------------------------------
// lcu_checker
// Port-level checks for the transcoder, bound to the top level.
// ----------------------------------------------------------------------------
module lcu_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_end
);

    logic in_beat;
    logic out_beat;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    // Hold a stalled output beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_end))
        else $error("utf8 beat changed while stalled");

    // Bytes of one group leave back to back
    a_group_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && !out_end |=> out_valid)
        else $error("gap inside a UTF-8 byte group");

    // An idle output with no fresh input means the input is ready
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !$past(in_beat) |-> in_ready)
        else $error("input stalled while transcoder idle");

    // No output during reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("output valid during reset");

endmodule

bind legacy_charset_to_utf8_transcoder_core lcu_checker u_lcu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (doc.valid),
    .in_ready  (doc.ready),
    .out_valid (utf8.valid),
    .out_ready (utf8.ready),
    .out_byte  (utf8.out_byte),
    .out_end   (utf8.out_end)
);
